// ===== sv/tcw_pkg.sv =====
// Shared types, constants and helpers for the text console writer.
// No dependencies; every module but tcw_ram imports this package.
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int ADDR_W = $clog2(CELLS);
	localparam int MODE_W = 2;
	localparam int CHAR_W = 8;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int WORD_W = 16;
	localparam int POS_W  = 11;

	localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'(CELLS - COLUMNS);
	localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);

	localparam logic [WORD_W-1:0] BLANK_WORD = 16'h0020;
	localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

	localparam logic [MODE_W-1:0] MODE_PUT    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SETCUR = 2'd2;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		OP_PUT,
		OP_TAB,
		OP_NEWLINE,
		OP_CLEAR,
		OP_SETCUR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [WORD_W-1:0] word;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  line;
		logic [ADDR_W-1:0] addr;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qpush_t;

	typedef struct packed {
		logic valid;
		logic full;
	} qstat_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
			input logic [ROW_W-1:0] line);
		return ADDR_W'(col) + ADDR_W'(line) * COLS_A;
	endfunction

endpackage

// ===== sv/tcw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone: no package dependency.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/tcw_front.sv =====
// Front end: accepts commands, classifies them, clamps coordinates and
// builds the queue entry. Depends on tcw_pkg.
module tcw_front (
	input  logic                       start,
	input  logic [tcw_pkg::MODE_W-1:0] mode,
	input  logic [tcw_pkg::CHAR_W-1:0] character,
	input  logic [tcw_pkg::CHAR_W-1:0] color,
	input  logic [tcw_pkg::COL_W-1:0]  column,
	input  logic [tcw_pkg::ROW_W-1:0]  row,
	input  tcw_pkg::qstat_t            qstat,
	input  logic                       init_busy,
	output logic                       busy,
	output tcw_pkg::qpush_t            push
);
	import tcw_pkg::*;

	logic [COL_W-1:0] col_sat;
	logic [ROW_W-1:0] row_sat;

	assign busy    = qstat.full | init_busy;
	assign col_sat = (column > COL_LAST) ? COL_LAST : column;
	assign row_sat = (row > ROW_LAST) ? ROW_LAST : row;

	always_comb begin
		push.valid    = start & ~busy;
		push.cmd.word = {color, character};
		push.cmd.col  = col_sat;
		push.cmd.line = row_sat;
		push.cmd.addr = cell_addr(col_sat, row_sat);
		case (mode)
			MODE_PUT: begin
				if (character == CHAR_NL) begin
					push.cmd.op = OP_NEWLINE;
				end else if (character == CHAR_TAB) begin
					push.cmd.op   = OP_TAB;
					push.cmd.word = {color, CHAR_SPACE};
				end else begin
					push.cmd.op = OP_PUT;
				end
			end
			MODE_CLEAR:  push.cmd.op = OP_CLEAR;
			MODE_SETCUR: push.cmd.op = OP_SETCUR;
			MODE_READ:   push.cmd.op = OP_READ;
			default:     push.cmd.op = OP_READ;
		endcase
	end

endmodule

// ===== sv/tcw_queue.sv =====
// Short command queue between the front end and the execution engine.
// Depends on tcw_pkg for the entry type and depth.
module tcw_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  tcw_pkg::qpush_t push,
	input  logic            pop,
	output tcw_pkg::qstat_t qstat,
	output tcw_pkg::cmd_t   head
);
	import tcw_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign qstat.valid = (count_q != '0);
	assign qstat.full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign do_push     = push.valid & ~qstat.full;
	assign do_pop      = pop & qstat.valid;
	assign head        = entry_q[rd_ptr_q];

	// depth is a power of two, so the pointers wrap on their own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.cmd;
		end
	end

endmodule

// ===== sv/tcw_back.sv =====
// Execution engine: owns the screen RAM and the cursor, carries out puts,
// newlines, scrolls, clears, cursor sets and reads, and drives the result
// strobe. Depends on tcw_pkg and tcw_ram.
module tcw_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tcw_pkg::qstat_t            qstat,
	input  tcw_pkg::cmd_t              head,
	output logic                       pop,
	output logic                       init_busy,
	output logic                       done,
	output logic [tcw_pkg::WORD_W-1:0] cell_data,
	output logic [tcw_pkg::COL_W-1:0]  cursor_column,
	output logic [tcw_pkg::ROW_W-1:0]  cursor_row,
	output logic [tcw_pkg::POS_W-1:0]  cursor_position
);
	import tcw_pkg::*;

	typedef enum logic [6:0] {
		ST_FILL  = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_PUT   = 7'b0000100,
		ST_SCRL  = 7'b0001000,
		ST_BLANK = 7'b0010000,
		ST_READ  = 7'b0100000,
		ST_RESP  = 7'b1000000
	} state_t;

	state_t            state_q;
	logic              init_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [1:0]        rep_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  line_q;
	cmd_t              cmd_q;
	logic              done_q;
	logic [WORD_W-1:0] data_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [POS_W-1:0]  out_pos_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_rdata;
	logic [ADDR_W-1:0] cur_addr;

	assign cur_addr  = cell_addr(col_q, line_q);
	assign pop       = (state_q == ST_IDLE) && qstat.valid;
	assign init_busy = init_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = BLANK_WORD;
		ram_raddr = '0;
		case (state_q)
			ST_FILL, ST_BLANK: begin
				ram_we = 1'b1;
			end
			ST_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = cur_addr;
				ram_wdata = cmd_q.word;
			end
			ST_SCRL: begin
				// read one row ahead, write the cell fetched last cycle
				if (cnt_q < SCROLL_END) begin
					ram_raddr = cnt_q + COLS_A;
				end
				ram_we    = (cnt_q != '0);
				ram_waddr = cnt_q - 1'b1;
				ram_wdata = ram_rdata;
			end
			ST_READ: begin
				ram_raddr = cmd_q.addr;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FILL;
			init_q    <= 1'b1;
			cnt_q     <= '0;
			rep_q     <= '0;
			col_q     <= '0;
			line_q    <= '0;
			done_q    <= 1'b0;
			data_q    <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			out_pos_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_FILL: begin
					if (cnt_q == CELL_LAST) begin
						cnt_q  <= '0;
						init_q <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_RESP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (qstat.valid) begin
						case (head.op)
							OP_PUT: begin
								rep_q   <= 2'd1;
								state_q <= ST_PUT;
							end
							OP_TAB: begin
								rep_q   <= 2'd3;
								state_q <= ST_PUT;
							end
							OP_NEWLINE: begin
								rep_q <= 2'd0;
								col_q <= '0;
								if (line_q == ROW_LAST) begin
									cnt_q   <= '0;
									state_q <= ST_SCRL;
								end else begin
									line_q  <= line_q + 1'b1;
									state_q <= ST_RESP;
								end
							end
							OP_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_FILL;
							end
							OP_SETCUR: begin
								col_q   <= head.col;
								line_q  <= head.line;
								state_q <= ST_RESP;
							end
							OP_READ: begin
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_PUT: begin
					rep_q <= rep_q - 1'b1;
					if (col_q == COL_LAST) begin
						col_q <= '0;
						if (line_q == ROW_LAST) begin
							cnt_q   <= '0;
							state_q <= ST_SCRL;
						end else begin
							line_q  <= line_q + 1'b1;
							state_q <= (rep_q == 2'd1) ? ST_RESP : ST_PUT;
						end
					end else begin
						col_q   <= col_q + 1'b1;
						state_q <= (rep_q == 2'd1) ? ST_RESP : ST_PUT;
					end
				end
				ST_SCRL: begin
					// hold the count: the blank sweep starts at the last row
					if (cnt_q == SCROLL_END) begin
						state_q <= ST_BLANK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_BLANK: begin
					if (cnt_q == CELL_LAST) begin
						cnt_q   <= '0;
						state_q <= (rep_q == 2'd0) ? ST_RESP : ST_PUT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_READ: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					done_q    <= 1'b1;
					data_q    <= (cmd_q.op == OP_READ) ? ram_rdata : '0;
					out_col_q <= col_q;
					out_row_q <= line_q;
					out_pos_q <= POS_W'(cur_addr);
					state_q   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
	end

	tcw_ram #(
		.WIDTH(WORD_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign done            = done_q;
	assign cell_data       = data_q;
	assign cursor_column   = out_col_q;
	assign cursor_row      = out_row_q;
	assign cursor_position = out_pos_q;

endmodule

// ===== sv/text_console_writer_core.sv =====
// Text console writer: a screen of 80 x 25 character cells (colour in the
// high byte, character in the low byte) with a cursor.
// Commands enter on start/mode/character/color/column/row and are taken at
// a clock edge where start is high and busy is low. A front end classifies
// each transaction and places it in a two-entry queue; the execution engine
// drains the queue through a single screen RAM (one write, one registered
// read per cycle); busy rises only on a full queue or the reset clear.
// Each command produces one result: done is high for exactly one cycle with
// cell_data and the cursor fields valid; the receiver cannot stall it.
// A scroll (put or newline past the bottom row) copies each cell up one row
// through the RAM port and its read register, then blanks the bottom row.
// A clear blanks every cell. The engine carries out one command at a time;
// the queue takes new commands while it has room.
// After reset the engine blanks the whole screen, one cell a cycle; busy
// stays high until this clearing pass ends.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
module text_console_writer_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [tcw_pkg::MODE_W-1:0] mode,
	input  logic [tcw_pkg::CHAR_W-1:0] character,
	input  logic [tcw_pkg::CHAR_W-1:0] color,
	input  logic [tcw_pkg::COL_W-1:0]  column,
	input  logic [tcw_pkg::ROW_W-1:0]  row,
	output logic                       done,
	output logic [tcw_pkg::WORD_W-1:0] cell_data,
	output logic [tcw_pkg::COL_W-1:0]  cursor_column,
	output logic [tcw_pkg::ROW_W-1:0]  cursor_row,
	output logic [tcw_pkg::POS_W-1:0]  cursor_position
);
	import tcw_pkg::*;

	qpush_t push;
	qstat_t qstat;
	cmd_t   head;
	logic   pop;
	logic   init_busy;

	tcw_front u_front (
		.start     (start),
		.mode      (mode),
		.character (character),
		.color     (color),
		.column    (column),
		.row       (row),
		.qstat     (qstat),
		.init_busy (init_busy),
		.busy      (busy),
		.push      (push)
	);

	tcw_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.qstat  (qstat),
		.head   (head)
	);

	tcw_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.qstat           (qstat),
		.head            (head),
		.pop             (pop),
		.init_busy       (init_busy),
		.done            (done),
		.cell_data       (cell_data),
		.cursor_column   (cursor_column),
		.cursor_row      (cursor_row),
		.cursor_position (cursor_position)
	);

endmodule

// ===== sv/tcw_checker.sv =====
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg.
module tcw_port_checks (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       done,
	input logic [tcw_pkg::COL_W-1:0]  cursor_column,
	input logic [tcw_pkg::ROW_W-1:0]  cursor_row,
	input logic [tcw_pkg::POS_W-1:0]  cursor_position
);
	import tcw_pkg::*;

	// results never come on consecutive cycles
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done high on two consecutive cycles");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cursor_column <= COL_LAST) && (cursor_row <= ROW_LAST))
		else $error("cursor outside the screen");

	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> cursor_position ==
			POS_W'(32'(cursor_column) + 32'(cursor_row) * 32'(COLUMNS)))
		else $error("cursor_position does not match column and row");

	// result fields change only with a new transaction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(cursor_column) && $stable(cursor_row)
			&& $stable(cursor_position))
		else $error("cursor fields changed without a result");

endmodule

bind text_console_writer_core tcw_port_checks u_tcw_checker (.*);
